>>> hdl/stpp_pkg.sv
// ----------------------------------------------------------------------------
// stpp_pkg: shared definitions for the sample to palette pixel mapper
// Palette size, register map, pixel class codes and request codes.
// ----------------------------------------------------------------------------
package stpp_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_COLOR_COUNT = 3'd0,
    REG_LOW_BOUND   = 3'd1,
    REG_GAIN        = 3'd2,
    REG_BLANK_VALUE = 3'd3,
    REG_UNDER_PIXEL = 3'd4,
    REG_OVER_PIXEL  = 3'd5,
    REG_BLANK_PIXEL = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_IN_RANGE = 2'd0,
    CLS_UNDER    = 2'd1,
    CLS_OVER     = 2'd2,
    CLS_BLANK    = 2'd3
  } pix_class_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_WRITE  = 1'b1
  } req_type_t;

  localparam logic [8:0]  COLOR_COUNT_RST = 9'd256;
  localparam logic [31:0] GAIN_RST        = 32'h0001_0000;

endpackage

>>> hdl/stpp_ram.sv
// ----------------------------------------------------------------------------
// stpp_ram: generic single-port RAM
// One access per cycle, either a write or a read; read data is registered
// and holds while the port is not enabled.
// ----------------------------------------------------------------------------
module stpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sample_to_palette_pixel.sv
// ----------------------------------------------------------------------------
// sample_to_palette_pixel: linear window colormap lookup
// Maps signed Q16.16 samples to 32-bit display pixels through a palette.
// ----------------------------------------------------------------------------
// One item is accepted every cycle while out_stall is low. A sample item
// passes the input register, window offset, the 32x32 product register,
// then the registered palette read that forms the result stage. Table write
// items travel the same stages, write the palette where a sample would read
// it and give no result, so a write is seen by every later sample. The whole
// pipeline advances together and in_stall is high only while a result waits
// and out_stall is high. Palette entries must be written before a sample
// reads them.
module sample_to_palette_pixel (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic signed [31:0]         in_sample,
  input  logic                       in_last_in,
  input  logic [7:0]                 in_entry_index,
  input  logic [31:0]                in_entry_pixel,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_pixel_out,
  output logic [1:0]                 out_pixel_class,
  output logic                       out_last_out,
  // configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [stpp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [stpp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [stpp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  import stpp_pkg::*;

  // configuration registers
  logic [8:0]  color_count_r;
  logic [31:0] low_bound_r;
  logic [31:0] gain_r;
  logic [31:0] blank_value_r;
  logic [31:0] under_pixel_r;
  logic [31:0] over_pixel_r;
  logic [31:0] blank_pixel_r;

  reg_idx_t cfg_idx;
  logic     cfg_wr;

  // pipeline
  logic        adv;

  logic        v0_r;
  req_type_t   typ0_r;
  logic [31:0] sample0_r;
  logic        last0_r;
  logic [7:0]  eidx0_r;
  logic [31:0] epix0_r;

  logic [32:0] diff;
  logic        v1_r;
  req_type_t   typ1_r;
  logic        blank1_r;
  logic        under1_r;
  logic [31:0] dpos1_r;
  logic        last1_r;
  logic [7:0]  eidx1_r;
  logic [31:0] epix1_r;

  logic        v2_r;
  req_type_t   typ2_r;
  logic        blank2_r;
  logic        under2_r;
  logic [63:0] prod2_r;
  logic        last2_r;
  logic [7:0]  eidx2_r;
  logic [31:0] epix2_r;

  logic [32:0] idx;
  logic        over;
  pix_class_t  cls_nxt;
  logic [31:0] pix_nxt;
  logic        eidx_ok;

  logic        ram_en;
  logic        ram_we;
  logic [PAL_AW-1:0] ram_addr;
  logic [31:0] ram_rdata;

  logic        out_valid_r;
  pix_class_t  out_class_r;
  logic [31:0] out_pix_r;
  logic        out_last_r;

  // ---------------------------------------------------------------- config
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= COLOR_COUNT_RST;
      low_bound_r   <= '0;
      gain_r        <= GAIN_RST;
      blank_value_r <= '0;
      under_pixel_r <= '0;
      over_pixel_r  <= '0;
      blank_pixel_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COLOR_COUNT: color_count_r <= cfg_pwdata[8:0];
        REG_LOW_BOUND:   low_bound_r   <= cfg_pwdata;
        REG_GAIN:        gain_r        <= cfg_pwdata;
        REG_BLANK_VALUE: blank_value_r <= cfg_pwdata;
        REG_UNDER_PIXEL: under_pixel_r <= cfg_pwdata;
        REG_OVER_PIXEL:  over_pixel_r  <= cfg_pwdata;
        REG_BLANK_PIXEL: blank_pixel_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COLOR_COUNT: cfg_prdata = {23'd0, color_count_r};
      REG_LOW_BOUND:   cfg_prdata = low_bound_r;
      REG_GAIN:        cfg_prdata = gain_r;
      REG_BLANK_VALUE: cfg_prdata = blank_value_r;
      REG_UNDER_PIXEL: cfg_prdata = under_pixel_r;
      REG_OVER_PIXEL:  cfg_prdata = over_pixel_r;
      REG_BLANK_PIXEL: cfg_prdata = blank_pixel_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------- control
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r && (typ2_r == REQ_SAMPLE);
    end
  end

  // --------------------------------------------------- stage 1: window offset
  assign diff = {sample0_r[31], sample0_r} - {low_bound_r[31], low_bound_r};

  // --------------------------------------------- stage 3: round and classify
  // Rounding half up: add one half of the Q32.32 product, keep the integer.
  assign idx  = {1'b0, prod2_r[63:32]} + {32'd0, prod2_r[31]};
  assign over = (idx >= {24'd0, color_count_r}) || (idx >= 33'(PAL_DEPTH));

  always_comb begin
    priority if (blank2_r) begin
      cls_nxt = CLS_BLANK;
      pix_nxt = blank_pixel_r;
    end else if (under2_r) begin
      cls_nxt = CLS_UNDER;
      pix_nxt = under_pixel_r;
    end else if (over) begin
      cls_nxt = CLS_OVER;
      pix_nxt = over_pixel_r;
    end else begin
      cls_nxt = CLS_IN_RANGE;
      pix_nxt = '0;
    end
  end

  assign eidx_ok  = 32'(eidx2_r) < 32'(PAL_DEPTH);
  assign ram_we   = (typ2_r == REQ_WRITE);
  assign ram_en   = adv && v2_r && (ram_we ? eidx_ok : (cls_nxt == CLS_IN_RANGE));
  assign ram_addr = ram_we ? PAL_AW'(eidx2_r) : idx[PAL_AW-1:0];

  stpp_ram #(
    .WIDTH(32),
    .DEPTH(PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (epix2_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (adv) begin
      typ0_r    <= req_type_t'(in_req_type);
      sample0_r <= in_sample;
      last0_r   <= in_last_in;
      eidx0_r   <= in_entry_index;
      epix0_r   <= in_entry_pixel;

      typ1_r   <= typ0_r;
      blank1_r <= (sample0_r == blank_value_r);
      under1_r <= diff[32] && (gain_r != '0);
      dpos1_r  <= diff[32] ? 32'd0 : diff[31:0];
      last1_r  <= last0_r;
      eidx1_r  <= eidx0_r;
      epix1_r  <= epix0_r;

      typ2_r   <= typ1_r;
      blank2_r <= blank1_r;
      under2_r <= under1_r;
      prod2_r  <= 64'(dpos1_r) * 64'(gain_r);
      last2_r  <= last1_r;
      eidx2_r  <= eidx1_r;
      epix2_r  <= epix1_r;

      out_class_r <= cls_nxt;
      out_pix_r   <= pix_nxt;
      out_last_r  <= last2_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_class = out_class_r;
  assign out_pixel_out   = (out_class_r == CLS_IN_RANGE) ? ram_rdata : out_pix_r;
  assign out_last_out    = out_last_r;

  // ------------------------------------------------------------ assertions
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r && typ2_r == REQ_WRITE) |=> !out_valid_r)
    else $error("table write item produced a result");

  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r && typ2_r == REQ_SAMPLE) |=> out_valid_r)
    else $error("sample item lost before the result stage");

  a_hold_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !adv) |=> (v0_r && $stable(sample0_r) && $stable(typ0_r)))
    else $error("input stage changed while the pipeline was held");

  a_blank_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_class_r == CLS_BLANK) |-> (out_pixel_out == blank_pixel_r))
    else $error("blank class without the blank pixel");

endmodule
